// ===== design/swor_pkg.sv =====
`default_nettype none

package swor_pkg;

    localparam int unsigned WINDOW_DEFAULT = 5;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SIGMA_W = 16;
    localparam int SAMPLE_MAX = 32767;

    // Pending-sample count; covers WINDOW up to 31 (HALF up to 15).
    localparam int unsigned PEND_W = 4;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_EARLY,
        KIND_FULL
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic                last;
        logic [PEND_W-1:0]   pend;
    } ctl_t;

    typedef struct packed {
        logic keep;
        logic neg;
    } verdict_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       replaced;
        logic                       end_of_stream;
    } result_t;

    function automatic int sum_width(input int window);
        return SAMPLE_W + $clog2(window) + 1;
    endfunction

    function automatic int spread_width(input int window);
        return 2 * SAMPLE_W + 2 * $clog2(window) + 1;
    endfunction

endpackage

`default_nettype wire

// ===== design/swor_if.sv =====
`default_nettype none

interface swor_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [swor_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;

    modport source (output valid, sample, last, input ready);
    modport sink (input valid, sample, last, output ready);
endinterface

interface swor_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [swor_pkg::SAMPLE_W-1:0] value;
    logic                                 replaced;
    logic                                 end_of_stream;

    modport source (output valid, value, replaced, end_of_stream, input ready);
    modport sink (input valid, value, replaced, end_of_stream, output ready);
endinterface

interface swor_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [swor_pkg::SIGMA_W-1:0]        sigma_limit;

    modport source (output valid, sigma_limit, input ready);
    modport sink (input valid, sigma_limit, output ready);
endinterface

`default_nettype wire

// ===== design/swor_window.sv =====
`default_nettype none

module swor_window #(
    parameter int unsigned WINDOW = swor_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    swor_sample_if.sink                               samples,
    output logic                                      v0,
    output swor_pkg::ctl_t                            ctl0,
    output logic signed [swor_pkg::SAMPLE_W-1:0]      win0 [WINDOW]
);

    localparam int HALF   = (WINDOW - 1) / 2;
    localparam int SEEN_W = $clog2(WINDOW + 1);
    localparam int PW     = swor_pkg::PEND_W;

    logic                                 accept;
    logic [SEEN_W-1:0]                    seen_reg, seen_next, seen_inc;
    logic                                 v0_reg;
    swor_pkg::ctl_t                       ctl0_reg, ctl0_next;
    logic signed [swor_pkg::SAMPLE_W-1:0] win_reg [WINDOW];

    assign samples.ready = en;
    assign accept        = samples.valid && en;

    always_comb
    begin
        seen_inc = (seen_reg < SEEN_W'(WINDOW)) ? seen_reg + 1'b1 : seen_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            seen_next = samples.last ? '0 : seen_inc;
        end
        ctl0_next.last = samples.last;
        ctl0_next.pend = '0;
        if (seen_inc <= SEEN_W'(HALF))
        begin
            ctl0_next.kind = swor_pkg::KIND_EARLY;
        end
        else if (seen_inc == SEEN_W'(WINDOW))
        begin
            ctl0_next.kind = swor_pkg::KIND_FULL;
            ctl0_next.pend = PW'(HALF);
        end
        else
        begin
            ctl0_next.kind = swor_pkg::KIND_NONE;
            ctl0_next.pend = PW'(seen_inc - SEEN_W'(HALF));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            v0_reg   <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (en)
            begin
                v0_reg <= samples.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WINDOW - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW-1] <= samples.sample;
            ctl0_reg <= ctl0_next;
        end
    end

    assign v0   = v0_reg;
    assign ctl0 = ctl0_reg;
    assign win0 = win_reg;

endmodule

`default_nettype wire

// ===== design/swor_stats.sv =====
`default_nettype none

module swor_stats #(
    parameter int unsigned WINDOW = swor_pkg::WINDOW_DEFAULT,
    localparam int HALF  = (WINDOW - 1) / 2,
    localparam int SUM_W = swor_pkg::sum_width(WINDOW),
    localparam int SP_W  = swor_pkg::spread_width(WINDOW)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic [swor_pkg::SIGMA_W-1:0]         sigma,
    input  wire logic                                 v0,
    input  swor_pkg::ctl_t                            ctl0,
    input  wire logic signed [swor_pkg::SAMPLE_W-1:0] win0 [WINDOW],
    output logic                                      v3,
    output swor_pkg::ctl_t                            ctl3,
    output logic [SP_W-1:0]                           spread3,
    output logic [SP_W-1:0]                           limsq3,
    output logic signed [swor_pkg::SAMPLE_W-1:0]      outlier3,
    output logic signed [SUM_W-1:0]                   sum3,
    output logic signed [swor_pkg::SAMPLE_W-1:0]      centre3,
    output logic signed [swor_pkg::SAMPLE_W-1:0]      tail3 [HALF]
);

    localparam int SW    = swor_pkg::SAMPLE_W;
    localparam int CW    = $clog2(WINDOW);
    localparam int P     = 1 << CW;
    localparam int SQ_W  = 2 * SW - 1;
    localparam int Q_W   = SQ_W + CW;
    localparam int DF_W  = SUM_W + 1;
    localparam int D_W   = SUM_W;
    localparam int LIM_W = swor_pkg::SIGMA_W + CW;

    localparam logic signed [DF_W-1:0] WIN_DF = DF_W'(WINDOW);

    // stage 1: sum and squares
    logic                       v1_reg;
    swor_pkg::ctl_t             ctl1_reg;
    logic signed [SW-1:0]       win1_reg [WINDOW];
    logic [SQ_W-1:0]            sq1_reg [WINDOW];
    logic signed [SUM_W-1:0]    sum1_reg;

    logic signed [SUM_W-1:0]    sum_t [CW+1][P];
    logic signed [2*SW-1:0]     sq_full [WINDOW];

    // stage 2: sum of squares, distances, limit
    logic                       v2_reg;
    swor_pkg::ctl_t             ctl2_reg;
    logic signed [SW-1:0]       win2_reg [WINDOW];
    logic [D_W-1:0]             dist2_reg [WINDOW];
    logic [Q_W-1:0]             q2_reg;
    logic signed [SUM_W-1:0]    sum2_reg;
    logic [LIM_W-1:0]           lim2_reg;

    logic [Q_W-1:0]             q_t [CW+1][P];
    logic signed [DF_W-1:0]     wx [WINDOW];
    logic signed [DF_W-1:0]     diff [WINDOW];
    logic [D_W-1:0]             dist_next [WINDOW];

    // stage 3: spread, squared limit, outlier
    logic                       v3_reg;
    swor_pkg::ctl_t             ctl3_reg;
    logic [SP_W-1:0]            spread3_reg;
    logic [SP_W-1:0]            limsq3_reg;
    logic signed [SW-1:0]       outlier3_reg;
    logic signed [SUM_W-1:0]    sum3_reg;
    logic signed [SW-1:0]       centre3_reg;
    logic signed [SW-1:0]       tail3_reg [HALF];

    logic [D_W-1:0]             am_d [CW+1][P];
    logic signed [SW-1:0]       am_x [CW+1][P];
    logic [SP_W-1:0]            wq;
    logic signed [2*SUM_W-1:0]  ss_full;
    logic [2*LIM_W-1:0]         lsq;
    logic signed [SW-1:0]       outlier_next;

    always_comb
    begin
        sum_t = '{default: '{default: '0}};
        for (int i = 0; i < WINDOW; i++)
        begin
            sum_t[0][i] = SUM_W'(win0[i]);
            sq_full[i]  = win0[i] * win0[i];
        end
        for (int l = 0; l < CW; l++)
        begin
            for (int i = 0; i < P / 2; i++)
            begin
                sum_t[l+1][i] = sum_t[l][2*i] + sum_t[l][2*i+1];
            end
        end
    end

    always_comb
    begin
        q_t = '{default: '{default: '0}};
        for (int i = 0; i < WINDOW; i++)
        begin
            q_t[0][i]    = Q_W'(sq1_reg[i]);
            wx[i]        = DF_W'(win1_reg[i]) * WIN_DF;
            diff[i]      = wx[i] - DF_W'(sum1_reg);
            dist_next[i] = diff[i][DF_W-1] ? D_W'(-diff[i]) : D_W'(diff[i]);
        end
        for (int l = 0; l < CW; l++)
        begin
            for (int i = 0; i < P / 2; i++)
            begin
                q_t[l+1][i] = q_t[l][2*i] + q_t[l][2*i+1];
            end
        end
    end

    // Ties keep the lower (older) entry.
    always_comb
    begin
        am_d = '{default: '{default: '0}};
        am_x = '{default: '{default: '0}};
        for (int i = 0; i < WINDOW; i++)
        begin
            am_d[0][i] = dist2_reg[i];
            am_x[0][i] = win2_reg[i];
        end
        for (int l = 0; l < CW; l++)
        begin
            for (int i = 0; i < P / 2; i++)
            begin
                if (am_d[l][2*i+1] > am_d[l][2*i])
                begin
                    am_d[l+1][i] = am_d[l][2*i+1];
                    am_x[l+1][i] = am_x[l][2*i+1];
                end
                else
                begin
                    am_d[l+1][i] = am_d[l][2*i];
                    am_x[l+1][i] = am_x[l][2*i];
                end
            end
        end
        outlier_next = (am_d[CW][0] != '0) ? am_x[CW][0] : '0;
        wq      = SP_W'(q2_reg) * SP_W'(WINDOW);
        ss_full = sum2_reg * sum2_reg;
        lsq     = lim2_reg * lim2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl1_reg <= ctl0;
            sum1_reg <= sum_t[CW][0];
            for (int i = 0; i < WINDOW; i++)
            begin
                win1_reg[i] <= win0[i];
                sq1_reg[i]  <= sq_full[i][SQ_W-1:0];
            end

            ctl2_reg <= ctl1_reg;
            sum2_reg <= sum1_reg;
            q2_reg   <= q_t[CW][0];
            lim2_reg <= LIM_W'(sigma) * LIM_W'(WINDOW);
            for (int i = 0; i < WINDOW; i++)
            begin
                win2_reg[i]  <= win1_reg[i];
                dist2_reg[i] <= dist_next[i];
            end

            ctl3_reg     <= ctl2_reg;
            sum3_reg     <= sum2_reg;
            spread3_reg  <= wq - SP_W'(ss_full);
            limsq3_reg   <= SP_W'(lsq);
            outlier3_reg <= outlier_next;
            centre3_reg  <= win2_reg[HALF];
            for (int k = 0; k < HALF; k++)
            begin
                tail3_reg[k] <= win2_reg[WINDOW-HALF+k];
            end
        end
    end

    assign v3       = v3_reg;
    assign ctl3     = ctl3_reg;
    assign spread3  = spread3_reg;
    assign limsq3   = limsq3_reg;
    assign outlier3 = outlier3_reg;
    assign sum3     = sum3_reg;
    assign centre3  = centre3_reg;
    assign tail3    = tail3_reg;

endmodule

`default_nettype wire

// ===== design/swor_mean.sv =====
`default_nettype none

module swor_mean #(
    parameter int unsigned WINDOW = swor_pkg::WINDOW_DEFAULT,
    localparam int HALF  = (WINDOW - 1) / 2,
    localparam int SUM_W = swor_pkg::sum_width(WINDOW),
    localparam int SP_W  = swor_pkg::spread_width(WINDOW)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 v3,
    input  swor_pkg::ctl_t                            ctl3,
    input  wire logic [SP_W-1:0]                      spread3,
    input  wire logic [SP_W-1:0]                      limsq3,
    input  wire logic signed [swor_pkg::SAMPLE_W-1:0] outlier3,
    input  wire logic signed [SUM_W-1:0]              sum3,
    input  wire logic signed [swor_pkg::SAMPLE_W-1:0] centre3,
    input  wire logic signed [swor_pkg::SAMPLE_W-1:0] tail3 [HALF],
    output logic                                      v6,
    output swor_pkg::ctl_t                            ctl6,
    output swor_pkg::verdict_t                        verdict6,
    output logic [SUM_W-1:0]                          quot6,
    output logic signed [swor_pkg::SAMPLE_W-1:0]      centre6,
    output logic signed [swor_pkg::SAMPLE_W-1:0]      tail6 [HALF]
);

    localparam int SW  = swor_pkg::SAMPLE_W;
    localparam int A_W = SUM_W;
    localparam int DIV = WINDOW - 1;
    // floor(2^A_W / DIV); the quotient estimate is low by at most one
    localparam logic [A_W-1:0] RECIP = A_W'((1 << A_W) / DIV);
    localparam logic [A_W-1:0] DIV_A = A_W'(DIV);

    logic                   v4_reg, v5_reg, v6_reg;
    swor_pkg::ctl_t         ctl4_reg, ctl5_reg, ctl6_reg;
    swor_pkg::verdict_t     vd4_reg, vd5_reg, vd6_reg;
    logic signed [SW-1:0]   centre4_reg, centre5_reg, centre6_reg;
    logic signed [SW-1:0]   tail4_reg [HALF];
    logic signed [SW-1:0]   tail5_reg [HALF];
    logic signed [SW-1:0]   tail6_reg [HALF];
    logic [A_W-1:0]         mag4_reg, mag5_reg;
    logic [2*A_W-1:0]       prod5_reg;
    logic [A_W-1:0]         quot6_reg;

    logic signed [SUM_W:0]  num;
    swor_pkg::verdict_t     vd4_next;
    logic [A_W-1:0]         mag4_next;
    logic [A_W-1:0]         q_est;
    logic [A_W-1:0]         rem;
    logic [A_W-1:0]         quot_next;

    always_comb
    begin
        num           = (SUM_W+1)'(sum3) - (SUM_W+1)'(outlier3);
        vd4_next.keep = spread3 < limsq3;
        vd4_next.neg  = num[SUM_W];
        mag4_next     = num[SUM_W] ? A_W'(-num) : A_W'(num);

        q_est     = prod5_reg[2*A_W-1:A_W];
        rem       = mag5_reg - q_est * DIV_A;
        quot_next = (rem >= DIV_A) ? q_est + 1'b1 : q_est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl4_reg    <= ctl3;
            vd4_reg     <= vd4_next;
            mag4_reg    <= mag4_next;
            centre4_reg <= centre3;

            ctl5_reg    <= ctl4_reg;
            vd5_reg     <= vd4_reg;
            mag5_reg    <= mag4_reg;
            prod5_reg   <= mag4_reg * RECIP;
            centre5_reg <= centre4_reg;

            ctl6_reg    <= ctl5_reg;
            vd6_reg     <= vd5_reg;
            quot6_reg   <= quot_next;
            centre6_reg <= centre5_reg;

            for (int k = 0; k < HALF; k++)
            begin
                tail4_reg[k] <= tail3[k];
                tail5_reg[k] <= tail4_reg[k];
                tail6_reg[k] <= tail5_reg[k];
            end
        end
    end

    assign v6       = v6_reg;
    assign ctl6     = ctl6_reg;
    assign verdict6 = vd6_reg;
    assign quot6    = quot6_reg;
    assign centre6  = centre6_reg;
    assign tail6    = tail6_reg;

endmodule

`default_nettype wire

// ===== design/swor_seq.sv =====
`default_nettype none

module swor_seq #(
    parameter int unsigned WINDOW = swor_pkg::WINDOW_DEFAULT,
    localparam int HALF  = (WINDOW - 1) / 2,
    localparam int SUM_W = swor_pkg::sum_width(WINDOW)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 v6,
    input  swor_pkg::ctl_t                            ctl6,
    input  swor_pkg::verdict_t                        verdict6,
    input  wire logic [SUM_W-1:0]                     quot6,
    input  wire logic signed [swor_pkg::SAMPLE_W-1:0] centre6,
    input  wire logic signed [swor_pkg::SAMPLE_W-1:0] tail6 [HALF],
    output logic                                      load_ok,
    swor_result_if.source                             results
);

    localparam int SW    = swor_pkg::SAMPLE_W;
    localparam int QD    = HALF + 1;
    localparam int CNT_W = $clog2(QD + 1);
    localparam int PW    = swor_pkg::PEND_W;

    localparam logic [SUM_W-1:0]     POS_LIM = SUM_W'(swor_pkg::SAMPLE_MAX);
    localparam logic [SUM_W-1:0]     NEG_LIM = SUM_W'(swor_pkg::SAMPLE_MAX + 1);
    localparam logic signed [SW-1:0] VAL_MAX = SW'(swor_pkg::SAMPLE_MAX);
    localparam logic signed [SW-1:0] VAL_MIN = {1'b1, {(SW-1){1'b0}}};

    swor_pkg::result_t  ent_reg [QD];
    logic [CNT_W-1:0]   cnt_reg;

    logic               take;
    logic               load;
    logic               has_first;
    swor_pkg::result_t  first;
    logic signed [SW-1:0] mean;
    logic [PW-1:0]      fl_cnt;
    swor_pkg::result_t  fl [QD];
    swor_pkg::result_t  ent_new [QD];
    logic [CNT_W-1:0]   cnt_new;

    assign take    = results.valid && results.ready;
    assign load_ok = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && results.ready);
    assign load    = v6 && load_ok;

    always_comb
    begin
        if (!verdict6.neg && quot6 > POS_LIM)
        begin
            mean = VAL_MAX;
        end
        else if (verdict6.neg && quot6 > NEG_LIM)
        begin
            mean = VAL_MIN;
        end
        else
        begin
            mean = verdict6.neg ? -(SW'(quot6)) : SW'(quot6);
        end

        first = '0;
        unique case (ctl6.kind)
            swor_pkg::KIND_EARLY:
            begin
                has_first           = 1'b1;
                first.value         = tail6[HALF-1];
                first.end_of_stream = ctl6.last;
            end
            swor_pkg::KIND_FULL:
            begin
                has_first      = 1'b1;
                first.value    = verdict6.keep ? centre6 : mean;
                first.replaced = !verdict6.keep;
            end
            swor_pkg::KIND_NONE:
            begin
                has_first = 1'b0;
            end
            default:
            begin
                has_first = 1'b0;
            end
        endcase

        // trailing samples, oldest first
        fl_cnt = ctl6.last ? ctl6.pend : '0;
        fl = '{default: '0};
        for (int f = 0; f < HALF; f++)
        begin
            for (int k = 0; k < HALF; k++)
            begin
                if (k == HALF - int'(ctl6.pend) + f)
                begin
                    fl[f].value = tail6[k];
                end
            end
            fl[f].end_of_stream = (PW'(f + 1) == fl_cnt);
        end

        ent_new[0] = has_first ? first : fl[0];
        for (int j = 1; j < QD; j++)
        begin
            ent_new[j] = has_first ? fl[j-1] : fl[j];
        end
        cnt_new = CNT_W'(has_first) + CNT_W'(fl_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= cnt_new;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= ent_new;
        end
        else if (take)
        begin
            for (int j = 0; j < QD - 1; j++)
            begin
                ent_reg[j] <= ent_reg[j+1];
            end
        end
    end

    assign results.valid         = (cnt_reg != '0);
    assign results.value         = ent_reg[0].value;
    assign results.replaced      = ent_reg[0].replaced;
    assign results.end_of_stream = ent_reg[0].end_of_stream;

endmodule

`default_nettype wire

// ===== design/sliding_window_outlier_replacer.sv =====
// Sliding-window outlier replacer. Signed 16-bit samples enter on the samples
// channel, one per clock unless held off; each stream ends with a transaction
// carrying last. Every position with a full centred window of WINDOW samples
// is tested with WINDOW*sumsq - sum^2 < (WINDOW*sigma_limit)^2: the centre
// passes unchanged, otherwise it is replaced by the mean of the window
// without its largest outlier, truncated toward zero and saturated to 16
// bits. The first and last (WINDOW-1)/2 positions, and short streams, pass
// through unchanged. Results pass the window register, three statistics
// stages, three mean-division stages and the output queue. The sample that
// ends a stream yields up to (WINDOW+1)/2 results, drained from the queue one
// per clock while results.ready is high; input is held off until the queue
// can take the next sample's results. The user must write sigma_limit on the
// cfg channel while the block is idle; the block does not enforce this.
`default_nettype none

module sliding_window_outlier_replacer #(
    parameter int unsigned WINDOW = swor_pkg::WINDOW_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    swor_sample_if.sink    samples,
    swor_result_if.source  results,
    swor_cfg_if.sink       cfg
);

    localparam int HALF  = (WINDOW - 1) / 2;
    localparam int SUM_W = swor_pkg::sum_width(WINDOW);
    localparam int SP_W  = swor_pkg::spread_width(WINDOW);
    localparam int SW    = swor_pkg::SAMPLE_W;

    logic [swor_pkg::SIGMA_W-1:0] sigma_reg;
    logic                         en;
    logic                         load_ok;

    logic                         v0, v3, v6;
    swor_pkg::ctl_t               ctl0, ctl3, ctl6;
    logic signed [SW-1:0]         win0 [WINDOW];
    logic [SP_W-1:0]              spread3, limsq3;
    logic signed [SW-1:0]         outlier3, centre3, centre6;
    logic signed [SUM_W-1:0]      sum3;
    logic signed [SW-1:0]         tail3 [HALF];
    logic signed [SW-1:0]         tail6 [HALF];
    swor_pkg::verdict_t           verdict6;
    logic [SUM_W-1:0]             quot6;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= '0;
        end
        else if (cfg.valid)
        begin
            sigma_reg <= cfg.sigma_limit;
        end
    end

    assign en = !v6 || load_ok;

    swor_window #(.WINDOW(WINDOW)) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .samples (samples),
        .v0      (v0),
        .ctl0    (ctl0),
        .win0    (win0)
    );

    swor_stats #(.WINDOW(WINDOW)) u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .sigma    (sigma_reg),
        .v0       (v0),
        .ctl0     (ctl0),
        .win0     (win0),
        .v3       (v3),
        .ctl3     (ctl3),
        .spread3  (spread3),
        .limsq3   (limsq3),
        .outlier3 (outlier3),
        .sum3     (sum3),
        .centre3  (centre3),
        .tail3    (tail3)
    );

    swor_mean #(.WINDOW(WINDOW)) u_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v3       (v3),
        .ctl3     (ctl3),
        .spread3  (spread3),
        .limsq3   (limsq3),
        .outlier3 (outlier3),
        .sum3     (sum3),
        .centre3  (centre3),
        .tail3    (tail3),
        .v6       (v6),
        .ctl6     (ctl6),
        .verdict6 (verdict6),
        .quot6    (quot6),
        .centre6  (centre6),
        .tail6    (tail6)
    );

    swor_seq #(.WINDOW(WINDOW)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .v6       (v6),
        .ctl6     (ctl6),
        .verdict6 (verdict6),
        .quot6    (quot6),
        .centre6  (centre6),
        .tail6    (tail6),
        .load_ok  (load_ok),
        .results  (results)
    );

endmodule

`default_nettype wire

// ===== sim/tb_sliding_window_outlier_replacer.sv =====
module tb_sliding_window_outlier_replacer;
    import swor_pkg::*;

    localparam int WIN = WINDOW_DEFAULT;
    localparam int HALF = (WIN - 1) / 2;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 400;

    class outlier_scoreboard;
        int window_vals[WIN];
        int unsigned stream_fill;
        int unsigned sigma;
        result_t pending_results[$];
        int errors;
        int checked;
        int replaced_seen;
        int samples_noted;
        int streams;
        int sigma_writes;

        function new();
            foreach (window_vals[i]) window_vals[i] = 0;
            stream_fill = 0;
            sigma = 0;
            errors = 0;
            checked = 0;
            replaced_seen = 0;
            samples_noted = 0;
            streams = 0;
            sigma_writes = 0;
        endfunction

        function void push_result(int v, bit rep, bit eos);
            result_t r;
            r.value = v[15:0];
            r.replaced = rep;
            r.end_of_stream = eos;
            pending_results.push_back(r);
        endfunction

        function int filtered_centre(output bit rep);
            longint s;
            longint q;
            longint spread;
            longint lim;
            longint best;
            longint outlier;
            longint d;
            longint m;
            s = 0;
            q = 0;
            best = 0;
            outlier = 0;
            for (int i = 0; i < WIN; i++)
            begin
                s += window_vals[i];
                q += longint'(window_vals[i]) * window_vals[i];
            end
            spread = WIN * q - s * s;
            lim = WIN * longint'(sigma);
            if (spread < lim * lim)
            begin
                rep = 1'b0;
                return window_vals[HALF];
            end
            for (int i = 0; i < WIN; i++)
            begin
                d = WIN * longint'(window_vals[i]) - s;
                if (d < 0)
                    d = -d;
                if (d > best)
                begin
                    best = d;
                    outlier = window_vals[i];
                end
            end
            m = (s - outlier) / (WIN - 1);
            if (m > 32767)
                m = 32767;
            if (m < -32768)
                m = -32768;
            rep = 1'b1;
            return int'(m);
        endfunction

        function void note_sample(logic signed [15:0] x, logic is_last);
            int pend;
            int v;
            bit rep;
            pend = 0;
            samples_noted++;
            for (int i = 0; i < WIN - 1; i++)
                window_vals[i] = window_vals[i + 1];
            window_vals[WIN - 1] = x;
            if (stream_fill < WIN)
                stream_fill++;
            if (stream_fill <= HALF)
                push_result(x, 1'b0, is_last);
            else if (stream_fill == WIN)
            begin
                v = filtered_centre(rep);
                push_result(v, rep, 1'b0);
                pend = HALF;
            end
            else
                pend = stream_fill - HALF;
            if (is_last)
            begin
                for (int i = 0; i < pend; i++)
                    push_result(window_vals[WIN - pend + i], 1'b0, i + 1 == pend);
                stream_fill = 0;
                streams++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            bit bad;
            bad = 1'b0;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: value %0d replaced %0b end_of_stream %0b",
                         $time, got.value, got.replaced, got.end_of_stream);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.replaced)
                replaced_seen++;
            if (got.value !== exp.value)
            begin
                $display("%0t value: expected %0d, got %0d", $time, exp.value, got.value);
                bad = 1'b1;
            end
            if (got.replaced !== exp.replaced)
            begin
                $display("%0t replaced: expected %0b, got %0b",
                         $time, exp.replaced, got.replaced);
                bad = 1'b1;
            end
            if (got.end_of_stream !== exp.end_of_stream)
            begin
                $display("%0t end_of_stream: expected %0b, got %0b",
                         $time, exp.end_of_stream, got.end_of_stream);
                bad = 1'b1;
            end
            if (bad)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit bursty = 1'b1;
    int unsigned cycles = 0;
    outlier_scoreboard sb = new();

    swor_sample_if samples_ch();
    swor_result_if results_ch();
    swor_cfg_if cfg_ch();

    sliding_window_outlier_replacer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch),
        .results(results_ch),
        .cfg(cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got.value = results_ch.value;
            got.replaced = results_ch.replaced;
            got.end_of_stream = results_ch.end_of_stream;
            sb.check_result(got);
        end
    end

    initial
    begin
        results_ch.ready <= 1'b0;
        forever
        begin
            if (bursty && $urandom_range(0, 3) == 0)
            begin
                results_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                results_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] x, input logic is_last);
        if (bursty && $urandom_range(0, 4) == 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.sample <= x;
        samples_ch.last <= is_last;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        sb.note_sample(x, is_last);
    endtask

    task automatic wait_drained(input int extra);
        samples_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_sigma(input logic [15:0] limit);
        wait_drained(DRAIN_CYCLES);
        cfg_ch.valid <= 1'b1;
        cfg_ch.sigma_limit <= limit;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.sigma = limit;
        sb.sigma_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample(int mode, int base, int amp);
        int v;
        case (mode)
            0: v = $urandom_range(0, 65535) - 32768;
            1:
            begin
                if ($urandom_range(0, 5) == 0)
                    v = $urandom_range(0, 65535) - 32768;
                else
                    v = base + $urandom_range(0, 2 * amp) - amp;
            end
            2: v = base;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic run_stream(input int len, input int mode);
        int base;
        int amp;
        base = $urandom_range(0, 65535) - 32768;
        amp = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 3000);
        if (mode == 2 && $urandom_range(0, 2) == 0)
            base = $urandom_range(0, 1) ? 32767 : -32768;
        for (int k = 0; k < len; k++)
        begin
            send_sample(pick_sample(mode, base, amp), k == len - 1);
            if (k < len - 1 && $urandom_range(0, 39) == 0)
                wait_drained(0);
        end
    endtask

    initial
    begin
        int len;
        int limit;
        rst_n = 1'b0;
        samples_ch.valid <= 1'b0;
        samples_ch.sample <= '0;
        samples_ch.last <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.sigma_limit <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sigma at reset value: every full window is replaced
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b1);
        for (int k = 0; k < WIN; k++)
            send_sample(-16'sd32768, k == WIN - 1);
        for (int k = 0; k < WIN; k++)
            send_sample(16'sd32767, k == WIN - 1);

        write_sigma(16'hFFFF);
        for (int k = 0; k < 6; k++)
            send_sample(k[0] ? -16'sd32768 : 16'sd32767, k == 5);

        // tied outliers, oldest wins; negative mean truncates toward zero
        write_sigma(16'd1);
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd0, 1'b1);

        while (sb.samples_noted < RANDOM_ITEMS + 26)
        begin
            if (sb.samples_noted > RANDOM_ITEMS - 60)
                bursty = 1'b0;
            case ($urandom_range(0, 5))
                0: limit = 0;
                1: limit = 65535;
                2, 3: limit = $urandom_range(1, 300);
                4: limit = $urandom_range(300, 8000);
                default: limit = $urandom_range(0, 65535);
            endcase
            write_sigma(limit[15:0]);
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, WIN - 1);
                else
                    len = $urandom_range(WIN, 30);
                run_stream(len, $urandom_range(0, 3));
            end
        end

        wait_drained(DRAIN_CYCLES);
        $display("Run covered %0d streams, %0d samples and %0d results (%0d replaced)",
                 sb.streams, sb.samples_noted, sb.checked, sb.replaced_seen);
        $display("across %0d sigma_limit settings, with and without back-pressure.",
                 sb.sigma_writes);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
